// ===== rtl/pal_pkg.sv =====
// Shared types and constants for the positional array list.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    // Fixed field widths of the command and result beats.
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF    = 64;
    localparam int ENTRY_WIDTH_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_REM_FRONT = 3'd3,
        ACT_REM_BACK  = 3'd4,
        ACT_REM_AT    = 3'd5,
        ACT_READ_AT   = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [POS_W-1:0]    position;
        logic [WORD_W-1:0]   entry_value;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   result_entry;
        logic [LEN_W-1:0]    list_length;
    } t_result;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_up;     // insert: cells at or above the slot move up
        logic shift_down;   // remove: cells at or above the slot pull from above
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/positional_array_list.sv =====
// Top level of the positional array list: command decode, length register,
// chain of pal_cell slots and the result register. Depends on pal_pkg, pal_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive i_cmd and raise i_start; the beat is taken at a
//   rising edge where i_start is high and o_busy is low. o_busy stays low,
//   so a command may be issued every cycle.
//   Result channel: o_done pulses for one cycle, in the cycle after the command
//   edge, with o_result (status, removed or read entry, new length). The
//   receiver cannot hold results off; it must take each beat as it comes.
//   Throughput 1 command per cycle: every slot of the cell chain shifts up or
//   down in the same edge, and the entry for a remove or read comes from a
//   one-hot pick across the slots before that edge.
//   Ordering: results leave in command order, exactly one per command.
//   Reset (i_rst_n low, synchronous) empties the list and drops any pending
//   result strobe. Slot contents are not cleared; only slots below the
//   length are ever read, and each of those has been written.
//   Insert when full gives status full, remove or read when empty gives
//   status empty, a bad position gives status bad-position; all leave the
//   list unchanged. Action code 7 is ignored with status ok.

module positional_array_list #(
    parameter int CAPACITY    = pal_pkg::CAPACITY_DEF,
    parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire pal_pkg::t_cmd   i_cmd,
    output logic                 o_busy,
    output logic                 o_done,
    output pal_pkg::t_result     o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = pal_pkg::POS_W;
    localparam int XW = (CW > PW) ? CW : PW;
    localparam int EW = ENTRY_WIDTH;
    localparam int WW = pal_pkg::WORD_W;
    localparam int LW = pal_pkg::LEN_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // List length and result beat.
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_done;
    pal_pkg::t_result     r_result;
    pal_pkg::t_result     n_result;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic [XW-1:0]        w_pos_x;
    logic [XW-1:0]        w_cnt_x;
    logic [CW-1:0]        w_cnt_m1;
    logic [IW-1:0]        w_at;
    logic                 w_take;       // remove or read: return the picked entry
    pal_pkg::t_cell_ctl   w_ctl;
    pal_pkg::t_cell_ctl   w_ctl_live;
    pal_pkg::t_status     w_status;
    logic [EW-1:0]        w_word;
    logic [EW-1:0]        w_pick;
    logic [EW-1:0]        w_data [CAPACITY];
    logic [EW-1:0]        w_tap  [CAPACITY];

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    assign w_full   = (r_count >= CAP_CNT);
    assign w_empty  = (r_count == '0);
    assign w_pos_x  = XW'(i_cmd.position);
    assign w_cnt_x  = XW'(r_count);
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_word   = EW'(i_cmd.entry_value);

    // Decode the command: pick the slot, the shift direction and the status.
    always_comb begin
        w_ctl    = '0;
        w_at     = '0;
        w_take   = 1'b0;
        w_status = pal_pkg::ST_OK;
        case (i_cmd.action)
            pal_pkg::ACT_INS_FRONT: begin
                if (w_full) begin
                    w_status = pal_pkg::ST_FULL;
                end else begin
                    w_ctl.shift_up = 1'b1;
                end
            end
            pal_pkg::ACT_INS_BACK: begin
                if (w_full) begin
                    w_status = pal_pkg::ST_FULL;
                end else begin
                    w_ctl.shift_up = 1'b1;
                    w_at           = r_count[IW-1:0];
                end
            end
            pal_pkg::ACT_INS_AT: begin
                if (w_full) begin
                    w_status = pal_pkg::ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    w_status = pal_pkg::ST_BADPOS;
                end else begin
                    w_ctl.shift_up = 1'b1;
                    w_at           = w_pos_x[IW-1:0];
                end
            end
            pal_pkg::ACT_REM_FRONT: begin
                if (w_empty) begin
                    w_status = pal_pkg::ST_EMPTY;
                end else begin
                    w_ctl.shift_down = 1'b1;
                    w_take           = 1'b1;
                end
            end
            pal_pkg::ACT_REM_BACK: begin
                if (w_empty) begin
                    w_status = pal_pkg::ST_EMPTY;
                end else begin
                    w_ctl.shift_down = 1'b1;
                    w_take           = 1'b1;
                    w_at             = w_cnt_m1[IW-1:0];
                end
            end
            pal_pkg::ACT_REM_AT, pal_pkg::ACT_READ_AT: begin
                if (w_empty) begin
                    w_status = pal_pkg::ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_status = pal_pkg::ST_BADPOS;
                end else begin
                    w_ctl.shift_down = (i_cmd.action == pal_pkg::ACT_REM_AT);
                    w_take           = 1'b1;
                    w_at             = w_pos_x[IW-1:0];
                end
            end
            default: begin
                // Unused action code: leave everything as it is.
                w_status = pal_pkg::ST_OK;
            end
        endcase
    end

    // Hold the chain unless a beat is actually taken.
    assign w_ctl_live = w_accept ? w_ctl : '0;

    // Cell chain: slot k trades entries with slots k-1 and k+1.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [EW-1:0] w_lower;
        logic [EW-1:0] w_upper;

        if (k == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_data[k+1];
        end

        pal_cell #(
            .INDEX (k),
            .IW    (IW),
            .EW    (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl_live),
            .i_at    (w_at),
            .i_word  (w_word),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    // Merge the one-hot taps into the addressed entry.
    always_comb begin
        w_pick = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_pick = w_pick | w_tap[k];
        end
    end

    // Advance the length.
    always_comb begin
        n_count = r_count;
        if (w_ctl_live.shift_up) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl_live.shift_down) begin
            n_count = w_cnt_m1;
        end
    end

    always_comb begin
        n_result.status       = w_status;
        n_result.result_entry = w_take ? WW'(w_pick) : '0;
        n_result.list_length  = LW'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    // Result payload carries no reset; the strobe qualifies it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("list length beyond capacity");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted command gave no result");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept))
        else $error("result strobe without a command");

    a_len_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.list_length == LW'(r_count)))
        else $error("reported length disagrees with list length");

    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == pal_pkg::ST_FULL)) |-> (r_count == CAP_CNT))
        else $error("full status while list has room");
`endif

endmodule

`default_nettype wire

// ===== rtl/pal_cell.sv =====
// One slot of the list chain: holds one entry and trades it with its neighbors.
// Depends on pal_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 6,
    parameter int EW    = 32
) (
    input  wire                   i_clk,
    input  wire  pal_pkg::t_cell_ctl i_ctl,
    input  wire  [IW-1:0]         i_at,
    input  wire  [EW-1:0]         i_word,
    input  wire  [EW-1:0]         i_lower,
    input  wire  [EW-1:0]         i_upper,
    output logic [EW-1:0]         o_data,
    output logic [EW-1:0]         o_tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;
    logic          w_hit;
    logic          w_above;

    assign w_hit   = (i_at == MY_IDX);
    assign w_above = (MY_IDX > i_at);

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            if (w_hit) begin
                n_data = i_word;
            end else if (w_above) begin
                n_data = i_lower;
            end
        end else if (i_ctl.shift_down) begin
            if (w_hit || w_above) begin
                n_data = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Drive the entry onto the pick bus only when this slot is addressed.
    assign o_tap  = w_hit ? r_data : '0;

endmodule

`default_nettype wire
